/* sv/gir_pkg.sv */
// Shared types, constants and sequencer codes for the increasing-run partition block.
package gir_pkg;

    localparam int DEF_MAX_RUNS   = 1024;
    localparam int DEF_VALUE_BITS = 32;
    localparam int IN_VALUE_W     = 32;
    localparam int RUN_INDEX_W    = 10;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic                  start_new;
    } gir_in_t;

    typedef struct packed {
        logic [RUN_INDEX_W-1:0] run_index;
        logic                   opened_run;
        logic                   overflow;
    } gir_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_FINISH
    } gir_state_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic in_ready;
        logic check;
        logic search;
        logic finish;
    } gir_ctl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic in_valid;
        logic fresh_empty;
        logic settle;
        logic out_free;
    } gir_sts_t;

endpackage

/* sv/greedy_increasing_run_partition.sv */
// Top level of the greedy increasing-run partition block (patience-sort pile assignment).
//
// Each accepted beat carries one value. The block places it on an increasing run and returns
// one result beat with the run index, whether a new run opened, and whether the run table was
// full. Run tails sit in a simple dual-port RAM (one write port, one registered read port). A
// small sequencer drives one shared less-than comparator against the tail just read.
// An item goes from accept straight to write-back when the table is empty or start_new is set.
// It passes through the tail check on the way when the last tail already bounds the value or
// only one run is open. Otherwise a binary search follows the check, with at most
// ceil(log2(runs)) steps. The RAM read port sets the pace: one probe of the tail table per cycle.
// Write-back waits while the output register holds an unclaimed result, and every such cycle
// adds to the item's time. in_ready is high only while the sequencer is idle.
// A finished result waits in the output register, so a new beat is taken while the previous
// result is still unclaimed. No clearing pass follows reset: only entries below the run count
// ever decide a result.
module greedy_increasing_run_partition
    import gir_pkg::*;
#(
    parameter int MAX_RUNS   = DEF_MAX_RUNS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  gir_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output gir_out_t out_data
);

    localparam int IDX_W = $clog2(MAX_RUNS);
    localparam int CNT_W = $clog2(MAX_RUNS + 1);

    gir_ctl_t ctl;
    gir_sts_t sts;

    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] v_reg;
    logic [VALUE_BITS-1:0] tail;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_eff;
    logic [IDX_W-1:0]      lo_reg;
    logic [IDX_W-1:0]      hi_reg;
    logic [IDX_W-1:0]      mid_reg;
    logic [IDX_W-1:0]      lo_next;
    logic [IDX_W-1:0]      hi_next;
    logic [IDX_W-1:0]      mid_next;
    logic [IDX_W:0]        mid_sum;
    logic [IDX_W-1:0]      last_idx;
    logic [IDX_W-1:0]      chk_mid;
    logic [IDX_W-1:0]      rd_addr;
    logic                  lt;
    logic                  full;
    logic                  opened_reg;
    logic                  ovf_reg;
    logic                  in_fire;
    logic                  out_free;
    logic                  finish_fire;
    logic                  ram_we;
    logic                  out_valid_reg;
    gir_out_t              out_data_reg;

    // Keep the low VALUE_BITS of the field, zero-extend when the tails are wider.
    assign in_val = VALUE_BITS'(in_data.value);

    assign in_fire     = in_valid && ctl.in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign finish_fire = ctl.finish && out_free;

    // Count after an optional clear by start_new.
    assign count_eff = in_data.start_new ? '0 : count_reg;
    assign full      = (count_reg == CNT_W'(MAX_RUNS));
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign chk_mid   = last_idx >> 1;

    // The one shared comparator: tail just read against the held value.
    assign lt = (tail < v_reg);

    // Search step: keep the half whose first tail below the value is still open.
    assign lo_next  = lt ? lo_reg : IDX_W'(mid_reg + IDX_W'(1));
    assign hi_next  = lt ? mid_reg : hi_reg;
    assign mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
    assign mid_next = mid_sum[IDX_W:1];

    // Probe address: last tail when idle, first midpoint on check, next one in search, else mid_reg.
    always_comb
    begin
        if (ctl.check)
        begin
            rd_addr = chk_mid;
        end
        else if (ctl.search)
        begin
            rd_addr = mid_next;
        end
        else if (ctl.in_ready)
        begin
            rd_addr = last_idx;
        end
        else
        begin
            rd_addr = mid_reg;
        end
    end

    assign sts.in_valid    = in_valid;
    assign sts.fresh_empty = (count_eff == '0);
    assign sts.settle      = ctl.check ? (!lt || (last_idx == '0)) : !(lo_next < hi_next);
    assign sts.out_free    = out_free;

    gir_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    assign ram_we = finish_fire && !ovf_reg;

    gir_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_RUNS)
    ) u_tails (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lo_reg),
        .wdata (v_reg),
        .raddr (rd_addr),
        .rdata (tail)
    );

    // Control state: run count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && in_data.start_new)
            begin
                count_reg <= '0;
            end
            else if (finish_fire && opened_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and search registers; lo_reg doubles as the chosen run index.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            v_reg      <= in_val;
            lo_reg     <= '0;
            opened_reg <= 1'b1;
            ovf_reg    <= 1'b0;
        end
        else if (ctl.check)
        begin
            hi_reg  <= last_idx;
            mid_reg <= chk_mid;
            if (!lt)
            begin
                // Last tail bounds the value: open a run at the end, or flag a full table.
                opened_reg <= !full;
                ovf_reg    <= full;
                lo_reg     <= full ? '0 : IDX_W'(count_reg);
            end
            else
            begin
                opened_reg <= 1'b0;
                ovf_reg    <= 1'b0;
                lo_reg     <= '0;
            end
        end
        else if (ctl.search)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end

        if (finish_fire)
        begin
            out_data_reg.run_index  <= RUN_INDEX_W'(lo_reg);
            out_data_reg.opened_run <= opened_reg;
            out_data_reg.overflow   <= ovf_reg;
        end
    end

    assign in_ready  = ctl.in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RUNS))
        else $error("run count beyond table size");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while an item was in flight");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.search |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("search probe outside its window");

    a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ctl.finish && out_free)
        else $error("tail written outside write-back");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> !out_data.opened_run && (out_data.run_index == '0))
        else $error("overflow result with a run index or opened run");
`endif

endmodule

/* sv/gir_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/gir_seq.sv */
// Sequencer: steps one item through tail check, binary search and write-back.
module gir_seq
    import gir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gir_sts_t sts,
    output gir_ctl_t ctl
);

    gir_state_t state_reg;
    gir_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = sts.fresh_empty ? ST_FINISH : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.settle ? ST_FINISH : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (sts.settle)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:   ctl.in_ready = 1'b1;
            ST_CHECK:  ctl.check    = 1'b1;
            ST_SEARCH: ctl.search   = 1'b1;
            ST_FINISH: ctl.finish   = 1'b1;
            default:   ctl = '0;
        endcase
    end

endmodule
